// ===== rtl/dmpr_pkg.sv =====
// ----------------------------------------------------------------------------
// dmpr_pkg: shared types and constants for the dual motor PWM drive
// Beat formats, command and direction codes, activity states, the percent to
// duty table and the reciprocal constants used for the divide by RAMP_STEPS.
// ----------------------------------------------------------------------------
package dmpr_pkg;

  // Block configuration.
  localparam int PWM_PERIOD_TICKS = 50;
  localparam int RAMP_STEPS       = 10;
  localparam int PCT_FULL         = 100;

  // Field widths fixed by the interface.
  localparam int CMD_W    = 3;
  localparam int DIR_W    = 2;
  localparam int PCT_IN_W = 8;
  localparam int DUR_W    = 16;
  localparam int PINS_W   = 4;

  // Internal widths derived from the configuration.
  localparam int PHASE_W = $clog2(PWM_PERIOD_TICKS);
  localparam int DUTY_W  = $clog2(PWM_PERIOD_TICKS + 1);
  localparam int PCT_W   = $clog2(PCT_FULL + 1);
  localparam int STEP_W  = $clog2(RAMP_STEPS + 1);
  localparam int ACC_W   = $clog2(PCT_FULL * (RAMP_STEPS + 1) + 1);
  localparam int HOLD_W  = $clog2((2 ** DUR_W - 1) / RAMP_STEPS + 1);

  // Reciprocal multiply for duration / RAMP_STEPS (exact over 16-bit inputs).
  localparam int HOLD_SHIFT  = DUR_W + $clog2(RAMP_STEPS);
  localparam int HOLD_MULT_W = DUR_W + 2;
  localparam logic [HOLD_MULT_W-1:0] HOLD_MULT =
    HOLD_MULT_W'((2 ** HOLD_SHIFT + RAMP_STEPS - 1) / RAMP_STEPS);

  // Reciprocal multiply for ramp accumulator / RAMP_STEPS.
  localparam int ACC_SHIFT  = ACC_W + $clog2(RAMP_STEPS);
  localparam int ACC_MULT_W = ACC_W + 2;
  localparam logic [ACC_MULT_W-1:0] ACC_MULT =
    ACC_MULT_W'((2 ** ACC_SHIFT + RAMP_STEPS - 1) / RAMP_STEPS);

  // Command codes; the eighth code is unused and ignored.
  typedef enum logic [CMD_W-1:0] {
    CMD_PWM_TICK   = 3'd0,
    CMD_MS_TICK    = 3'd1,
    CMD_SET_DIR    = 3'd2,
    CMD_SET_DUTY   = 3'd3,
    CMD_SOFT_START = 3'd4,
    CMD_BRAKE      = 3'd5,
    CMD_STOP       = 3'd6
  } cmd_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_FORWARD = 2'd0,
    DIR_REVERSE = 2'd1,
    DIR_RIGHT   = 2'd2,
    DIR_LEFT    = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    ACT_IDLE  = 2'd0,
    ACT_RAMP  = 2'd1,
    ACT_BRAKE = 2'd2
  } act_t;

  // Pin patterns: bit 0 left one, bit 1 left two, bit 2 right one, bit 3 right two.
  localparam logic [PINS_W-1:0] PINS_OFF   = 4'h0;
  localparam logic [PINS_W-1:0] PINS_BRAKE = 4'hF;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [DIR_W-1:0]    direction;
    logic [PCT_IN_W-1:0] percent_a;
    logic [PCT_IN_W-1:0] percent_b;
    logic [DUR_W-1:0]    duration_ms;
  } item_t;

  typedef struct packed {
    logic enable_a;
    logic enable_b;
    logic left_pin_one;
    logic left_pin_two;
    logic right_pin_one;
    logic right_pin_two;
    logic busy_res;
  } result_t;

  typedef logic [DUTY_W-1:0] duty_t;
  typedef logic [PCT_W-1:0]  pct_t;

  localparam int PCT_TABLE_DEPTH = 2 ** PCT_W;
  typedef duty_t duty_table_t [PCT_TABLE_DEPTH];

  // Duty in ticks for each percent; codes above full scale read as full.
  function automatic duty_table_t build_duty_table();
    duty_table_t t;
    int          p;
    for (int i = 0; i < PCT_TABLE_DEPTH; i++) begin
      p    = (i > PCT_FULL) ? PCT_FULL : i;
      t[i] = DUTY_W'((p * PWM_PERIOD_TICKS) / PCT_FULL);
    end
    return t;
  endfunction

  localparam duty_table_t DUTY_TABLE = build_duty_table();

  localparam duty_t DUTY_ZERO = '0;
  localparam duty_t DUTY_FULL = DUTY_W'(PWM_PERIOD_TICKS);

  // Saturate an incoming percent to full scale.
  function automatic pct_t sat_pct(logic [PCT_IN_W-1:0] p);
    pct_t r;
    if (p > PCT_IN_W'(PCT_FULL)) begin
      r = PCT_W'(PCT_FULL);
    end else begin
      r = p[PCT_W-1:0];
    end
    return r;
  endfunction

  // H-bridge pin pattern for a direction code.
  function automatic logic [PINS_W-1:0] dir_pins(logic [DIR_W-1:0] d);
    logic [PINS_W-1:0] r;
    case (d)
      DIR_FORWARD: r = 4'h5;
      DIR_REVERSE: r = 4'hA;
      DIR_RIGHT:   r = 4'h9;
      DIR_LEFT:    r = 4'h6;
      default:     r = PINS_OFF;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/dual_motor_pwm_ramp_brake.sv =====
// ----------------------------------------------------------------------------
// dual_motor_pwm_ramp_brake: two-channel H-bridge PWM drive
// Top level with the beat handshake and the result register.
// ----------------------------------------------------------------------------
// Every input beat (PWM tick, millisecond tick or command) yields exactly one
// result beat with the pin levels after it. The block sustains one beat per
// clock: the state update and the pin levels are computed combinationally
// between the accepted beat and the result register, and a new beat is taken
// whenever the result register is empty or its beat is being taken in the
// same cycle.
// While a soft start ramp or a brake hold runs, commands other than ticks are
// ignored and busy_res reads high.
module dual_motor_pwm_ramp_brake (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  dmpr_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output dmpr_pkg::result_t result
);

  logic              accept;
  dmpr_pkg::result_t next_result;

  // Take a new beat whenever the result register frees up this cycle.
  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  dmpr_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (item),
    .next_result (next_result)
  );

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= next_result;
    end
  end

endmodule

// ===== rtl/dmpr_core.sv =====
// ----------------------------------------------------------------------------
// dmpr_core: drive state and per-beat update
// Holds the PWM phase, duties, direction pins and the ramp / brake sequencer.
// Each accepted beat updates the state registers, and the pin levels after
// that beat are presented combinationally for the result register.
// ----------------------------------------------------------------------------
module dmpr_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  dmpr_pkg::item_t item,
  output dmpr_pkg::result_t next_result
);

  // State registers.
  logic [dmpr_pkg::PHASE_W-1:0] pwm_phase, pwm_phase_next;
  dmpr_pkg::duty_t              duty_a, duty_a_next;
  dmpr_pkg::duty_t              duty_b, duty_b_next;
  dmpr_pkg::pct_t               ramp_target_a, ramp_target_a_next;
  dmpr_pkg::pct_t               ramp_target_b, ramp_target_b_next;
  logic [dmpr_pkg::ACC_W-1:0]   ramp_acc_a, ramp_acc_a_next;
  logic [dmpr_pkg::ACC_W-1:0]   ramp_acc_b, ramp_acc_b_next;
  logic [dmpr_pkg::STEP_W-1:0]  ramp_step, ramp_step_next;
  logic [dmpr_pkg::HOLD_W-1:0]  step_hold_ms, step_hold_ms_next;
  logic [dmpr_pkg::DUR_W-1:0]   hold_left_ms, hold_left_ms_next;
  logic [dmpr_pkg::PINS_W-1:0]  direction_pins, direction_pins_next;
  dmpr_pkg::act_t               act, act_next;

  // Decoded beat and timer conditions.
  logic                         is_ms_tick;
  logic                         hold_expire;
  logic                         ramp_last;
  logic                         start_zero;
  logic                         brake_zero;
  logic [dmpr_pkg::DUR_W-1:0]   hold_dec;
  dmpr_pkg::pct_t               sat_a, sat_b;

  // Divide by RAMP_STEPS through reciprocal multiplies.
  logic [dmpr_pkg::DUR_W+dmpr_pkg::HOLD_MULT_W-1:0] hold_prod;
  logic [dmpr_pkg::HOLD_W-1:0]                      hold_quot;
  logic [dmpr_pkg::ACC_W+dmpr_pkg::ACC_MULT_W-1:0]  ramp_prod_a, ramp_prod_b;
  dmpr_pkg::pct_t                                   ramp_pct_a, ramp_pct_b;

  assign hold_prod   = dmpr_pkg::DUR_W'(item.duration_ms) * dmpr_pkg::HOLD_MULT;
  assign hold_quot   = hold_prod[dmpr_pkg::HOLD_SHIFT +: dmpr_pkg::HOLD_W];
  assign ramp_prod_a = ramp_acc_a * dmpr_pkg::ACC_MULT;
  assign ramp_prod_b = ramp_acc_b * dmpr_pkg::ACC_MULT;
  assign ramp_pct_a  = ramp_prod_a[dmpr_pkg::ACC_SHIFT +: dmpr_pkg::PCT_W];
  assign ramp_pct_b  = ramp_prod_b[dmpr_pkg::ACC_SHIFT +: dmpr_pkg::PCT_W];

  assign is_ms_tick  = accept && (item.command == dmpr_pkg::CMD_MS_TICK);
  assign hold_dec    = (hold_left_ms == '0) ? '0 : hold_left_ms - 1'b1;
  assign hold_expire = (hold_dec == '0);
  assign ramp_last   = (ramp_step >= dmpr_pkg::STEP_W'(dmpr_pkg::RAMP_STEPS));
  assign start_zero  = (item.duration_ms < dmpr_pkg::DUR_W'(dmpr_pkg::RAMP_STEPS));
  assign brake_zero  = (item.duration_ms == '0);
  assign sat_a       = dmpr_pkg::sat_pct(item.percent_a);
  assign sat_b       = dmpr_pkg::sat_pct(item.percent_b);

  // Activity sequencer: next state.
  always_comb begin
    act_next = act;
    case (act)
      dmpr_pkg::ACT_IDLE: begin
        if (accept && item.command == dmpr_pkg::CMD_SOFT_START && !start_zero) begin
          act_next = dmpr_pkg::ACT_RAMP;
        end else if (accept && item.command == dmpr_pkg::CMD_BRAKE && !brake_zero) begin
          act_next = dmpr_pkg::ACT_BRAKE;
        end
      end
      dmpr_pkg::ACT_RAMP: begin
        if (is_ms_tick && hold_expire && ramp_last) begin
          act_next = dmpr_pkg::ACT_IDLE;
        end
      end
      dmpr_pkg::ACT_BRAKE: begin
        if (is_ms_tick && hold_expire) begin
          act_next = dmpr_pkg::ACT_IDLE;
        end
      end
      default: act_next = dmpr_pkg::ACT_IDLE;
    endcase
  end

  // Datapath: phase, duties, pins and ramp bookkeeping.
  always_comb begin
    pwm_phase_next      = pwm_phase;
    duty_a_next         = duty_a;
    duty_b_next         = duty_b;
    ramp_target_a_next  = ramp_target_a;
    ramp_target_b_next  = ramp_target_b;
    ramp_acc_a_next     = ramp_acc_a;
    ramp_acc_b_next     = ramp_acc_b;
    ramp_step_next      = ramp_step;
    step_hold_ms_next   = step_hold_ms;
    hold_left_ms_next   = hold_left_ms;
    direction_pins_next = direction_pins;
    if (accept) begin
      case (item.command)
        dmpr_pkg::CMD_PWM_TICK: begin
          if (pwm_phase == dmpr_pkg::PHASE_W'(dmpr_pkg::PWM_PERIOD_TICKS - 1)) begin
            pwm_phase_next = '0;
          end else begin
            pwm_phase_next = pwm_phase + 1'b1;
          end
        end
        dmpr_pkg::CMD_MS_TICK: begin
          if (act == dmpr_pkg::ACT_RAMP) begin
            hold_left_ms_next = hold_dec;
            if (hold_expire && !ramp_last) begin
              // Next ramp step: the accumulator already holds target * step.
              ramp_step_next    = ramp_step + 1'b1;
              duty_a_next       = dmpr_pkg::DUTY_TABLE[ramp_pct_a];
              duty_b_next       = dmpr_pkg::DUTY_TABLE[ramp_pct_b];
              ramp_acc_a_next   = ramp_acc_a + dmpr_pkg::ACC_W'(ramp_target_a);
              ramp_acc_b_next   = ramp_acc_b + dmpr_pkg::ACC_W'(ramp_target_b);
              hold_left_ms_next = dmpr_pkg::DUR_W'(step_hold_ms);
            end
          end else if (act == dmpr_pkg::ACT_BRAKE) begin
            hold_left_ms_next = hold_dec;
            if (hold_expire) begin
              direction_pins_next = dmpr_pkg::PINS_OFF;
              duty_a_next         = dmpr_pkg::DUTY_ZERO;
              duty_b_next         = dmpr_pkg::DUTY_ZERO;
            end
          end
        end
        dmpr_pkg::CMD_SET_DIR: begin
          if (act == dmpr_pkg::ACT_IDLE) begin
            direction_pins_next = dmpr_pkg::dir_pins(item.direction);
          end
        end
        dmpr_pkg::CMD_SET_DUTY: begin
          if (act == dmpr_pkg::ACT_IDLE) begin
            duty_a_next = dmpr_pkg::DUTY_TABLE[sat_a];
            duty_b_next = dmpr_pkg::DUTY_TABLE[sat_b];
          end
        end
        dmpr_pkg::CMD_SOFT_START: begin
          if (act == dmpr_pkg::ACT_IDLE) begin
            ramp_target_a_next = sat_a;
            ramp_target_b_next = sat_b;
            ramp_acc_a_next    = dmpr_pkg::ACC_W'(sat_a);
            ramp_acc_b_next    = dmpr_pkg::ACC_W'(sat_b);
            step_hold_ms_next  = hold_quot;
            if (start_zero) begin
              // Zero step hold: jump straight to the full targets.
              ramp_step_next    = dmpr_pkg::STEP_W'(dmpr_pkg::RAMP_STEPS);
              duty_a_next       = dmpr_pkg::DUTY_TABLE[sat_a];
              duty_b_next       = dmpr_pkg::DUTY_TABLE[sat_b];
              hold_left_ms_next = '0;
            end else begin
              ramp_step_next    = '0;
              duty_a_next       = dmpr_pkg::DUTY_ZERO;
              duty_b_next       = dmpr_pkg::DUTY_ZERO;
              hold_left_ms_next = dmpr_pkg::DUR_W'(hold_quot);
            end
          end
        end
        dmpr_pkg::CMD_BRAKE: begin
          if (act == dmpr_pkg::ACT_IDLE) begin
            if (brake_zero) begin
              direction_pins_next = dmpr_pkg::PINS_OFF;
              duty_a_next         = dmpr_pkg::DUTY_ZERO;
              duty_b_next         = dmpr_pkg::DUTY_ZERO;
            end else begin
              direction_pins_next = dmpr_pkg::PINS_BRAKE;
              duty_a_next         = dmpr_pkg::DUTY_FULL;
              duty_b_next         = dmpr_pkg::DUTY_FULL;
              hold_left_ms_next   = item.duration_ms;
            end
          end
        end
        dmpr_pkg::CMD_STOP: begin
          if (act == dmpr_pkg::ACT_IDLE) begin
            direction_pins_next = dmpr_pkg::PINS_OFF;
            duty_a_next         = dmpr_pkg::DUTY_ZERO;
            duty_b_next         = dmpr_pkg::DUTY_ZERO;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Pin levels after the beat.
  always_comb begin
    next_result.enable_a      = (dmpr_pkg::DUTY_W'(pwm_phase_next) < duty_a_next);
    next_result.enable_b      = (dmpr_pkg::DUTY_W'(pwm_phase_next) < duty_b_next);
    next_result.left_pin_one  = direction_pins_next[0];
    next_result.left_pin_two  = direction_pins_next[1];
    next_result.right_pin_one = direction_pins_next[2];
    next_result.right_pin_two = direction_pins_next[3];
    next_result.busy_res      = (act_next != dmpr_pkg::ACT_IDLE);
  end

  // State update.
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_phase      <= '0;
      duty_a         <= '0;
      duty_b         <= '0;
      ramp_target_a  <= '0;
      ramp_target_b  <= '0;
      ramp_acc_a     <= '0;
      ramp_acc_b     <= '0;
      ramp_step      <= '0;
      step_hold_ms   <= '0;
      hold_left_ms   <= '0;
      direction_pins <= dmpr_pkg::PINS_OFF;
      act            <= dmpr_pkg::ACT_IDLE;
    end else begin
      pwm_phase      <= pwm_phase_next;
      duty_a         <= duty_a_next;
      duty_b         <= duty_b_next;
      ramp_target_a  <= ramp_target_a_next;
      ramp_target_b  <= ramp_target_b_next;
      ramp_acc_a     <= ramp_acc_a_next;
      ramp_acc_b     <= ramp_acc_b_next;
      ramp_step      <= ramp_step_next;
      step_hold_ms   <= step_hold_ms_next;
      hold_left_ms   <= hold_left_ms_next;
      direction_pins <= direction_pins_next;
      act            <= act_next;
    end
  end

  // A running ramp or brake always has time left on its hold counter.
  a_busy_hold_nonzero: assert property (@(posedge clk) disable iff (rst)
    (act != dmpr_pkg::ACT_IDLE) |-> (hold_left_ms != '0))
    else $error("busy with an empty hold counter");

  // The ramp never runs past its last step.
  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    ramp_step <= dmpr_pkg::STEP_W'(dmpr_pkg::RAMP_STEPS))
    else $error("ramp step beyond last step");

  // The PWM phase stays inside one period.
  a_phase_in_range: assert property (@(posedge clk) disable iff (rst)
    pwm_phase < dmpr_pkg::PHASE_W'(dmpr_pkg::PWM_PERIOD_TICKS))
    else $error("PWM phase out of range");

  // During a brake hold the bridge is shorted at full duty.
  a_brake_drive: assert property (@(posedge clk) disable iff (rst)
    (act == dmpr_pkg::ACT_BRAKE) |->
      (direction_pins == dmpr_pkg::PINS_BRAKE && duty_a == dmpr_pkg::DUTY_FULL &&
       duty_b == dmpr_pkg::DUTY_FULL))
    else $error("brake hold without full drive");

endmodule
